// ===== src/cdq_pkg.sv =====
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types and constants for the circular deque: operation and status
// codes, controller states and the result word passed to the output stage.
// ----------------------------------------------------------------------------
package cdq_pkg;

	localparam int DATA_W   = 32;
	localparam int KIND_W   = 3;
	localparam int STATUS_W = 2;

	// Operation codes carried in the kind field of a command word.
	typedef enum logic [KIND_W-1:0] {
		KIND_PUSH_REAR  = 3'd0,
		KIND_PUSH_FRONT = 3'd1,
		KIND_POP_FRONT  = 3'd2,
		KIND_POP_REAR   = 3'd3,
		KIND_PEEK_FRONT = 3'd4,
		KIND_PEEK_REAR  = 3'd5
	} kind_t;

	// Status codes returned with every response word.
	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK    = 2'd0,
		STATUS_FULL  = 2'd1,
		STATUS_EMPTY = 2'd2
	} status_t;

	// Controller states.
	typedef enum logic {
		ST_IDLE,
		ST_READ
	} state_t;

	// Response word handed from the controller to the output register.
	typedef struct packed {
		logic signed [DATA_W-1:0] read_value;
		logic [STATUS_W-1:0]      status;
		logic                     is_empty;
		logic                     is_full;
	} result_t;

endpackage

// ===== src/cdq_if.sv =====
// ----------------------------------------------------------------------------
// cdq_if
// Valid/ready channels of the circular deque: the command channel that
// carries one operation per word and the response channel.
// ----------------------------------------------------------------------------
interface cdq_cmd_if;
	logic                                 valid;
	logic                                 ready;
	logic [cdq_pkg::KIND_W-1:0]           kind;
	logic signed [cdq_pkg::DATA_W-1:0]    value;

	modport source (output valid, output kind, output value, input ready);
	modport sink   (input valid, input kind, input value, output ready);
endinterface

interface cdq_rsp_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [cdq_pkg::DATA_W-1:0]    read_value;
	logic [cdq_pkg::STATUS_W-1:0]         status;
	logic                                 is_empty;
	logic                                 is_full;

	modport source (output valid, output read_value, output status,
		output is_empty, output is_full, input ready);
	modport sink   (input valid, input read_value, input status,
		input is_empty, input is_full, output ready);
endinterface

// ===== src/circular_deque.sv =====
// ----------------------------------------------------------------------------
// circular_deque
// Double-ended queue of up to DEPTH-1 words kept in a ring store RAM.
// ----------------------------------------------------------------------------
// Timing: a push or rejected operation shows its response in the cycle after
// acceptance; a pop or peek goes through the store's registered read port,
// then the output register. Throughput: one push or rejected operation per
// cycle while the output is free; no new word is taken during a pop or peek.
// Reset: front and rear indices clear to zero; store contents are not
// cleared and no clearing pass runs, so the block is ready right away.
module circular_deque #(
	parameter int DEPTH = 128
) (
	input  logic      clk,
	input  logic      arst_n,
	cdq_cmd_if.sink   cmd,
	cdq_rsp_if.source rsp
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic                           res_valid;
	logic                           res_free;
	cdq_pkg::result_t               res;
	logic                           ram_we;
	logic [AW-1:0]                  ram_waddr;
	logic [cdq_pkg::DATA_W-1:0]     ram_wdata;
	logic                           ram_re;
	logic [AW-1:0]                  ram_raddr;
	logic [cdq_pkg::DATA_W-1:0]     ram_rdata;

	// Index control and operation sequencing.
	cdq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cmd.valid),
		.in_ready  (cmd.ready),
		.in_kind   (cmd.kind),
		.in_value  (cmd.value),
		.res_valid (res_valid),
		.res       (res),
		.res_free  (res_free),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	// Ring store.
	cdq_ram #(.WIDTH(cdq_pkg::DATA_W), .DEPTH(DEPTH)) u_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_en   (ram_re),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata)
	);

	// Response register.
	cdq_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.res_free  (res_free),
		.rsp       (rsp)
	);

endmodule

// ===== src/cdq_ram.sv =====
// ----------------------------------------------------------------------------
// cdq_ram
// Generic single-write, single-read synchronous RAM with a registered read
// port. Contents are not reset.
// ----------------------------------------------------------------------------
module cdq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== src/cdq_ctrl.sv =====
// ----------------------------------------------------------------------------
// cdq_ctrl
// Deque controller: holds the front and rear indices, decodes each command
// word, writes pushed words into the ring store and issues reads for pops
// and peeks, then builds the response word.
// ----------------------------------------------------------------------------
module cdq_ctrl #(
	parameter int DEPTH = 128,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [cdq_pkg::KIND_W-1:0]        in_kind,
	input  logic signed [cdq_pkg::DATA_W-1:0] in_value,
	output logic                              res_valid,
	output cdq_pkg::result_t                  res,
	input  logic                              res_free,
	output logic                              ram_we,
	output logic [AW-1:0]                     ram_waddr,
	output logic [cdq_pkg::DATA_W-1:0]        ram_wdata,
	output logic                              ram_re,
	output logic [AW-1:0]                     ram_raddr,
	input  logic [cdq_pkg::DATA_W-1:0]        ram_rdata
);

	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	cdq_pkg::state_t state_q, state_d;
	logic [AW-1:0]   front_q, front_d;
	logic [AW-1:0]   rear_q, rear_d;
	logic [AW-1:0]   addr_q, addr_d;

	// Decoded operation against the current indices.
	logic [AW-1:0]                 op_front;
	logic [AW-1:0]                 op_rear;
	logic                          op_wr;
	logic [AW-1:0]                 op_waddr;
	logic                          op_rd;
	logic [AW-1:0]                 op_raddr;
	logic [cdq_pkg::STATUS_W-1:0]  op_status;
	logic                          cur_empty;
	logic                          cur_full;
	logic                          cmd_fire;

	function automatic logic [AW-1:0] slot_next(input logic [AW-1:0] i);
		return (i == LAST) ? '0 : i + AW'(1);
	endfunction

	function automatic logic [AW-1:0] slot_prev(input logic [AW-1:0] i);
		return (i == '0) ? LAST : i - AW'(1);
	endfunction

	assign cur_empty = (front_q == rear_q);
	assign cur_full  = (slot_next(rear_q) == front_q);
	assign cmd_fire  = in_valid && in_ready;

	// Operation decode: index updates, store access and status.
	always_comb begin
		op_front  = front_q;
		op_rear   = rear_q;
		op_wr     = 1'b0;
		op_waddr  = slot_next(rear_q);
		op_rd     = 1'b0;
		op_raddr  = rear_q;
		op_status = cdq_pkg::STATUS_OK;
		case (cdq_pkg::kind_t'(in_kind))
			cdq_pkg::KIND_PUSH_REAR: begin
				if (cur_full) begin
					op_status = cdq_pkg::STATUS_FULL;
				end else begin
					op_rear  = slot_next(rear_q);
					op_wr    = 1'b1;
					op_waddr = slot_next(rear_q);
				end
			end
			cdq_pkg::KIND_PUSH_FRONT: begin
				if (cur_full) begin
					op_status = cdq_pkg::STATUS_FULL;
				end else begin
					op_front = slot_prev(front_q);
					op_wr    = 1'b1;
					op_waddr = front_q;
				end
			end
			cdq_pkg::KIND_POP_FRONT: begin
				if (cur_empty) begin
					op_status = cdq_pkg::STATUS_EMPTY;
				end else begin
					op_front = slot_next(front_q);
					op_rd    = 1'b1;
					op_raddr = slot_next(front_q);
				end
			end
			cdq_pkg::KIND_POP_REAR: begin
				if (cur_empty) begin
					op_status = cdq_pkg::STATUS_EMPTY;
				end else begin
					op_rear  = slot_prev(rear_q);
					op_rd    = 1'b1;
					op_raddr = rear_q;
				end
			end
			cdq_pkg::KIND_PEEK_FRONT: begin
				if (cur_empty) begin
					op_status = cdq_pkg::STATUS_EMPTY;
				end else begin
					op_rd    = 1'b1;
					op_raddr = slot_next(front_q);
				end
			end
			cdq_pkg::KIND_PEEK_REAR: begin
				if (cur_empty) begin
					op_status = cdq_pkg::STATUS_EMPTY;
				end else begin
					op_rd    = 1'b1;
					op_raddr = rear_q;
				end
			end
			default: begin
				// Undefined operation codes leave the deque untouched.
				op_status = cdq_pkg::STATUS_OK;
			end
		endcase
	end

	// Next state, store accesses and the response word.
	always_comb begin
		state_d        = state_q;
		front_d        = front_q;
		rear_d         = rear_q;
		addr_d         = addr_q;
		in_ready       = 1'b0;
		res_valid      = 1'b0;
		res.read_value = '0;
		res.status     = cdq_pkg::STATUS_OK;
		res.is_empty   = cur_empty;
		res.is_full    = cur_full;
		ram_we         = 1'b0;
		ram_waddr      = op_waddr;
		ram_wdata      = in_value;
		ram_re         = 1'b0;
		ram_raddr      = op_raddr;
		case (state_q)
			cdq_pkg::ST_IDLE: begin
				in_ready = res_free;
				if (cmd_fire) begin
					front_d = op_front;
					rear_d  = op_rear;
					ram_we  = op_wr;
					ram_re  = op_rd;
					addr_d  = op_raddr;
					if (op_rd) begin
						state_d = cdq_pkg::ST_READ;
					end else begin
						res_valid    = 1'b1;
						res.status   = op_status;
						res.is_empty = (op_front == op_rear);
						res.is_full  = (slot_next(op_rear) == op_front);
					end
				end
			end
			cdq_pkg::ST_READ: begin
				// Keep reading the same slot until the output stage takes it.
				ram_re         = 1'b1;
				ram_raddr      = addr_q;
				res_valid      = 1'b1;
				res.read_value = $signed(ram_rdata);
				if (res_free) begin
					state_d = cdq_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = cdq_pkg::ST_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cdq_pkg::ST_IDLE;
			front_q <= '0;
			rear_q  <= '0;
		end else begin
			state_q <= state_d;
			front_q <= front_d;
			rear_q  <= rear_d;
		end
	end

	// Read address held across the memory latency.
	always_ff @(posedge clk) begin
		addr_q <= addr_d;
	end

	// A pop or peek on a non-empty deque always enters the read state to wait for the store.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_fire && op_rd |=> state_q == cdq_pkg::ST_READ)
		else $error("read operation did not enter the read state");

	// A rejected operation leaves both indices unchanged.
	assert property (@(posedge clk) disable iff (!arst_n)
		cmd_fire && (op_status != cdq_pkg::STATUS_OK) |=>
		$stable(front_q) && $stable(rear_q))
		else $error("rejected operation moved an index");

	// No store write while a read result is pending.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == cdq_pkg::ST_READ |-> !ram_we)
		else $error("store written during a pending read");

	// Indices stay inside the ring.
	assert property (@(posedge clk) disable iff (!arst_n)
		(front_q <= LAST) && (rear_q <= LAST))
		else $error("index outside the ring store");

endmodule

// ===== src/cdq_out.sv =====
// ----------------------------------------------------------------------------
// cdq_out
// Output register of the deque: holds one response word until the sink
// takes it, and tells the controller when it can accept another.
// ----------------------------------------------------------------------------
module cdq_out (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             res_valid,
	input  cdq_pkg::result_t res,
	output logic             res_free,
	cdq_rsp_if.source        rsp
);

	logic             valid_q;
	cdq_pkg::result_t data_q;

	// The register is free when empty or being drained this cycle.
	assign res_free = !valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (res_free) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_free && res_valid) begin
			data_q <= res;
		end
	end

	assign rsp.valid      = valid_q;
	assign rsp.read_value = data_q.read_value;
	assign rsp.status     = data_q.status;
	assign rsp.is_empty   = data_q.is_empty;
	assign rsp.is_full    = data_q.is_full;

endmodule
